// ----- hdl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and codes for the chained hash set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;
  localparam int KeyW = 31;
  localparam int OpW = 2;
  localparam int StatW = 2;
  localparam int BucketFieldW = 6;
  localparam int CfgW = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_FREE_WAIT,
    S_NODE_WAIT,
    S_NODE_EVAL,
    S_DONE
  } state_t;

  // Register index.
  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
endpackage
`default_nettype wire

// ----- hdl/chs_mod.sv -----
// ----------------------------------------------------------------------------
// chs_mod
// Restoring divider: key modulo bucket count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chs_mod #(
  parameter int BW = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic [chs_pkg::KeyW-1:0] dividend,
  input  wire logic [BW:0]            divisor,
  output logic                        done,
  output logic [BW:0]                 remainder
);
  import chs_pkg::*;

  localparam int CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0] quo_r, quo_nxt;
  logic [BW+1:0]   rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic [BW+1:0]   trial;

  always_comb begin
    trial = {rem_r[BW:0], quo_r[KeyW-1]};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (go) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CntW'(KeyW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[KeyW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem_nxt = trial - {1'b0, divisor};
      else rem_nxt = trial;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = run_r && (cnt_r == CntW'(1));
  assign remainder = (trial >= {1'b0, divisor}) ? (BW+1)'(trial - {1'b0, divisor})
                                               : trial[BW:0];
endmodule
`default_nettype wire

// ----- hdl/chained_hash_set.sv -----
// ----------------------------------------------------------------------------
// chained_hash_set
// Each request runs through the bit-serial divider, then reads the bucket
// head (insert also pops the free stack) and walks the chain node by node.
// Throughput: one request at a time; the next may be accepted in the result
// cycle. The receiver cannot stall.
// Reset (synchronous, rst_n low) clears the bucket heads, one per cycle;
// busy stays high until it finishes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_set #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire logic [chs_pkg::OpW-1:0]  in_op,
  input  wire logic [chs_pkg::KeyW-1:0] in_key,
  output logic      out_valid,
  output logic [chs_pkg::StatW-1:0]        out_status,
  output logic [chs_pkg::BucketFieldW-1:0] out_bucket,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chs_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int PW = NW + 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

  // Configuration
  logic [CfgW-1:0] bcount_r;
  logic [BW:0]     act_buckets;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) bcount_r <= CfgW'(64);
    else if (psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT))
      bcount_r <= pwdata[CfgW-1:0];
  end
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? {{(32-CfgW){1'b0}}, bcount_r} : 32'd0;
  always_comb begin
    if (bcount_r == '0) act_buckets = (BW+1)'(1);
    else if (32'(bcount_r) > MAX_BUCKETS) act_buckets = (BW+1)'(MAX_BUCKETS);
    else act_buckets = (BW+1)'(bcount_r);
  end

  // Control
  state_t          state_r, state_nxt;
  op_t             op_r;
  logic [KeyW-1:0] key_r;
  logic [BW-1:0]   bkt_r, bkt_nxt;
  logic [BW-1:0]   clr_r, clr_nxt;
  logic [PW-1:0]   fcnt_r, fcnt_nxt;
  logic [PW-1:0]   cur_r, cur_nxt, prev_r, prev_nxt;
  logic [PW-1:0]   steps_r, steps_nxt;
  logic [NW-1:0]   nd_r, nd_nxt;
  logic [StatW-1:0] stat_r, stat_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic [NW:0]     fill_r, fill_nxt;   // lowest free stack entry popped so far
  logic            mod_go, mod_done;
  logic [BW:0]     mod_rem;
  logic            accept;

  // Memories
  logic [PW-1:0]   head_mem [MAX_BUCKETS];
  logic [KeyW-1:0] key_mem  [POOL_NODES];
  logic [PW-1:0]   link_mem [POOL_NODES];
  logic [NW-1:0]   free_mem [POOL_NODES];

  logic            head_we;  logic [BW-1:0] head_wa; logic [PW-1:0] head_wd;
  logic [BW-1:0]   head_ra;  logic [PW-1:0] head_rd_r;
  logic            key_we;   logic [NW-1:0] key_wa;
  logic            link_we;  logic [NW-1:0] link_wa; logic [PW-1:0] link_wd;
  logic [NW-1:0]   node_ra;  logic [KeyW-1:0] key_rd_r; logic [PW-1:0] link_rd_r;
  logic            free_we;  logic [NW-1:0] free_wa;  logic [NW-1:0] free_wd;
  logic [NW-1:0]   free_ra;  logic [NW-1:0] free_rd_r;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_r;
    key_rd_r <= key_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_r <= free_mem[free_ra];
  end

  chs_mod #(.BW(BW)) u_mod (
    .clk(clk), .rst_n(rst_n), .go(mod_go), .dividend(in_key),
    .divisor(act_buckets), .done(mod_done), .remainder(mod_rem)
  );

  assign accept = start && !busy;
  assign mod_go = accept;

  // Free stack: entries below fill_r are implicitly POOL_NODES-1-i.
  logic [NW-1:0] free_top_idx;
  logic [NW-1:0] free_val;
  assign free_top_idx = NW'(fcnt_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (32'(clr_r) == MAX_BUCKETS - 1) state_nxt = S_IDLE;
      S_IDLE:      if (accept) state_nxt = S_MOD;
      S_MOD:       if (mod_done) state_nxt = S_HEAD_RD;
      S_HEAD_RD:   state_nxt = (op_r == OP_NONE) ? S_DONE
                             : ((op_r == OP_INSERT) ? S_FREE_WAIT : S_HEAD_WAIT);
      S_FREE_WAIT: state_nxt = S_HEAD_WAIT;
      S_HEAD_WAIT: state_nxt = (op_r == OP_INSERT && stat_r == ST_FULL) ? S_DONE
                             : ((head_rd_r < NIL) ? S_NODE_WAIT : S_DONE);
      S_NODE_WAIT: state_nxt = S_NODE_EVAL;
      S_NODE_EVAL: state_nxt = (cur_nxt < NIL && steps_nxt < NIL && stat_nxt == ST_NOTFOUND
                               && !(op_r == OP_INSERT)) ? S_NODE_WAIT
                             : ((op_r == OP_INSERT && link_rd_r < NIL &&
                                 steps_nxt < NIL) ? S_NODE_WAIT : S_DONE);
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  assign free_val = ({1'b0, free_top_idx} >= fill_r) ? free_rd_r
                  : NW'(POOL_NODES - 1) - free_top_idx;

  always_comb begin
    bkt_nxt = bkt_r; clr_nxt = clr_r; fcnt_nxt = fcnt_r; cur_nxt = cur_r;
    prev_nxt = prev_r; steps_nxt = steps_r; nd_nxt = nd_r; stat_nxt = stat_r;
    ovalid_nxt = 1'b0; fill_nxt = fill_r;
    head_we = 1'b0; head_wa = bkt_r; head_wd = NIL; head_ra = bkt_r;
    key_we = 1'b0; key_wa = nd_r;
    link_we = 1'b0; link_wa = nd_r; link_wd = NIL;
    node_ra = cur_r[NW-1:0];
    free_we = 1'b0; free_wa = fcnt_r[NW-1:0]; free_wd = cur_r[NW-1:0];
    free_ra = free_top_idx;
    unique case (state_r)
      S_CLEAR: begin
        head_we = 1'b1; head_wa = clr_r; head_wd = NIL;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        stat_nxt = ST_NOTFOUND;
        steps_nxt = '0;
        prev_nxt = NIL;
      end
      S_MOD: if (mod_done) bkt_nxt = BW'(mod_rem);
      S_HEAD_RD: begin
        head_ra = bkt_r;
        if (op_r == OP_INSERT && fcnt_r == '0) stat_nxt = ST_FULL;
      end
      S_FREE_WAIT: begin
        if (stat_r != ST_FULL) begin
          nd_nxt = free_val;
          fcnt_nxt = fcnt_r - 1'b1;
          stat_nxt = ST_DONE;
          if ({1'b0, free_top_idx} < fill_r) fill_nxt = {1'b0, free_top_idx};
        end
      end
      S_HEAD_WAIT: begin
        cur_nxt = head_rd_r;
        node_ra = head_rd_r[NW-1:0];
        if (op_r == OP_INSERT && stat_r != ST_FULL) begin
          key_we = 1'b1; link_we = 1'b1; link_wa = nd_r; link_wd = NIL;
          if (!(head_rd_r < NIL)) begin
            head_we = 1'b1; head_wa = bkt_r; head_wd = {1'b0, nd_r};
          end
        end
      end
      S_NODE_WAIT: ;
      S_NODE_EVAL: begin
        steps_nxt = steps_r + 1'b1;
        if (op_r == OP_INSERT) begin
          if (link_rd_r < NIL && steps_nxt < NIL) begin
            cur_nxt = link_rd_r; node_ra = link_rd_r[NW-1:0];
          end else begin
            link_we = 1'b1; link_wa = cur_r[NW-1:0]; link_wd = {1'b0, nd_r};
          end
        end else if (key_rd_r == key_r) begin
          stat_nxt = ST_DONE;
          if (op_r == OP_REMOVE) begin
            if (prev_r < NIL) begin
              link_we = 1'b1; link_wa = prev_r[NW-1:0]; link_wd = link_rd_r;
            end else begin
              head_we = 1'b1; head_wa = bkt_r; head_wd = link_rd_r;
            end
            if (fcnt_r < NIL) begin
              free_we = 1'b1; free_wa = fcnt_r[NW-1:0]; free_wd = cur_r[NW-1:0];
              fcnt_nxt = fcnt_r + 1'b1;
            end
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt = link_rd_r;
          node_ra = link_rd_r[NW-1:0];
        end
      end
      S_DONE: ovalid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      fcnt_r <= NIL;
      fill_r <= NIL;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      fcnt_r <= fcnt_nxt;
      fill_r <= fill_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (accept) begin
      op_r <= op_t'(in_op);
      key_r <= in_key;
    end
    bkt_r <= bkt_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt;
    steps_r <= steps_nxt; nd_r <= nd_nxt; stat_r <= stat_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_status = stat_r;
  assign out_bucket = BucketFieldW'(bkt_r);

`ifndef SYNTHESIS
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n) fcnt_r <= NIL)
    else $error("free count out of range");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("missing result");
  a_full_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE_WAIT && stat_r == ST_FULL) |=> $stable(fcnt_r))
    else $error("allocated from empty pool");
`endif
endmodule
`default_nettype wire

// ----- test/chs_checker.sv -----
// ----------------------------------------------------------------------------
// chs_checker
// Watches the request, result and register ports of the chained hash set.
// Keeps its own copy of the buckets, node pool and free stack, predicts the
// status and bucket of every accepted request, and compares each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chs_checker
  import chs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OpW-1:0]          in_op,
  input  logic [KeyW-1:0]         in_key,
  input  logic                    out_valid,
  input  logic [StatW-1:0]        out_status,
  input  logic [BucketFieldW-1:0] out_bucket,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      fail_count,
  output int                      pending,
  output int                      result_count
);
  localparam int NBKT = 64;
  localparam int NNODE = 256;
  localparam int NIL = NNODE;

  typedef struct packed {
    status_t                 status;
    logic [BucketFieldW-1:0] bucket;
  } hash_reply_t;

  hash_reply_t    replies_due[$];
  int             heads[NBKT];
  logic [KeyW-1:0] node_key[NNODE];
  int             node_next[NNODE];
  int             free_stack[NNODE];
  int             free_cnt;
  logic [CfgW-1:0] bkt_reg;

  function automatic int live_buckets();
    if (bkt_reg == 0) return 1;
    if (bkt_reg > NBKT) return NBKT;
    return int'(bkt_reg);
  endfunction

  task automatic hash_apply(input op_t op, input logic [KeyW-1:0] key,
                            output hash_reply_t r);
    int b;
    int cur;
    int prv;
    int steps;
    int nd;
    b = int'(key % live_buckets());
    r.status = ST_NOTFOUND;
    r.bucket = b[BucketFieldW-1:0];
    case (op)
      OP_INSERT: begin
        if (free_cnt == 0) begin
          r.status = ST_FULL;
        end else begin
          free_cnt--;
          nd = free_stack[free_cnt];
          node_key[nd] = key;
          node_next[nd] = NIL;
          if (heads[b] == NIL) begin
            heads[b] = nd;
          end else begin
            cur = heads[b];
            steps = 0;
            while (node_next[cur] != NIL && steps < NNODE) begin
              cur = node_next[cur];
              steps++;
            end
            node_next[cur] = nd;
          end
          r.status = ST_DONE;
        end
      end
      OP_SEARCH: begin
        cur = heads[b];
        steps = 0;
        while (cur != NIL && steps < NNODE) begin
          if (node_key[cur] == key) begin
            r.status = ST_DONE;
            break;
          end
          cur = node_next[cur];
          steps++;
        end
      end
      OP_REMOVE: begin
        prv = NIL;
        cur = heads[b];
        steps = 0;
        while (cur != NIL && steps < NNODE) begin
          if (node_key[cur] == key) begin
            if (prv != NIL) node_next[prv] = node_next[cur];
            else heads[b] = node_next[cur];
            node_next[cur] = NIL;
            if (free_cnt < NNODE) begin
              free_stack[free_cnt] = cur;
              free_cnt++;
            end
            r.status = ST_DONE;
            break;
          end
          prv = cur;
          cur = node_next[cur];
          steps++;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    hash_reply_t want;
    hash_reply_t got;
    if (!rst_n) begin
      replies_due.delete();
      bkt_reg = 7'd64;
      for (int i = 0; i < NBKT; i++) heads[i] = NIL;
      for (int i = 0; i < NNODE; i++) begin
        node_next[i] = NIL;
        free_stack[i] = NNODE - 1 - i;
      end
      free_cnt = NNODE;
    end else begin
      if (out_valid) begin
        result_count++;
        got.status = status_t'(out_status);
        got.bucket = out_bucket;
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word status %0d bucket %0d",
                   $time, out_status, out_bucket);
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
          end
          if (got.bucket != want.bucket) begin
            fail_count++;
            $display("%0t: bucket mismatch, expected %0d actual %0d",
                     $time, want.bucket, got.bucket);
          end
        end
      end
      if (start && !busy) begin
        hash_apply(op_t'(in_op), in_key, want);
        replies_due.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == {REG_BUCKET_COUNT, 2'b00})
        bkt_reg = pwdata[CfgW-1:0];
    end
    pending = replies_due.size();
  end
endmodule

// ----- test/tb_chained_hash_set.sv -----
// ----------------------------------------------------------------------------
// tb_chained_hash_set
// Drives the chained hash set with directed and random insert, search and
// remove words under several bucket counts, including a pool-full phase,
// in bursts with random gaps. A checker beside the block predicts results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_chained_hash_set;
  import chs_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OpW-1:0]          in_op;
  logic [KeyW-1:0]         in_key;
  logic                    out_valid;
  logic [StatW-1:0]        out_status;
  logic [BucketFieldW-1:0] out_bucket;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  int                      fail_count;
  int                      pending;
  int                      result_count;
  int                      words_sent;
  int                      burst_left;
  int                      idle_cycles;

  chained_hash_set u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key),
    .out_valid(out_valid), .out_status(out_status), .out_bucket(out_bucket),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  chs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key),
    .out_valid(out_valid), .out_status(out_status), .out_bucket(out_bucket),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic [KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start = 1'b1;
    in_op = op;
    in_key = key;
    while (busy) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_buckets(input logic [CfgW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_BUCKET_COUNT, 2'b00};
    pwdata = {25'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return KeyW'($urandom_range(0, 199));
    if (r < 95) return KeyW'($urandom);
    return {KeyW{1'b1}};
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return OP_INSERT;
    if (r < 66) return OP_SEARCH;
    if (r < 95) return OP_REMOVE;
    return OP_NONE;
  endfunction

  initial begin
    logic [CfgW-1:0] settings[6];
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_INSERT;
    in_key = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    words_sent = 0;
    burst_left = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, duplicates, misses, unused op
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, {KeyW{1'b1}});
    send_word(OP_SEARCH, '0);
    send_word(OP_SEARCH, {KeyW{1'b1}});
    send_word(OP_SEARCH, 31'd64);
    send_word(OP_INSERT, 31'h2AAAAAAA);
    send_word(OP_INSERT, 31'h2AAAAAAA);
    send_word(OP_INSERT, 31'h5555556A);
    send_word(OP_REMOVE, 31'h2AAAAAAA);
    send_word(OP_SEARCH, 31'h2AAAAAAA);
    send_word(OP_REMOVE, 31'h2AAAAAAA);
    send_word(OP_SEARCH, 31'h2AAAAAAA);
    send_word(OP_REMOVE, 31'h2AAAAAAA);
    send_word(OP_REMOVE, 31'd5);
    send_word(OP_NONE, 31'd77);
    send_word(OP_REMOVE, '0);
    send_word(OP_REMOVE, {KeyW{1'b1}});
    drain();

    // one bucket: fill the pool past full, then empty it
    write_buckets(7'd1);
    for (int i = 0; i < 258; i++) send_word(OP_INSERT, KeyW'(i));
    send_word(OP_SEARCH, 31'd255);
    send_word(OP_SEARCH, 31'd256);
    for (int i = 0; i < 256; i++) send_word(OP_REMOVE, KeyW'(i));
    drain();

    settings = '{7'd64, 7'd0, 7'd127, 7'd7, 7'd33, 7'd2};
    for (int p = 0; p < 6; p++) begin
      write_buckets(p == 5 ? 7'($urandom_range(1, 64)) : settings[p]);
      for (int i = 0; i < 160; i++) begin
        send_word(pick_op(), pick_key());
        if (p == 2 && i == 80) drain();
      end
      drain();
    end

    $display("Sent %0d request words over eight bucket settings, pool full included;",
             words_sent);
    $display("checked %0d result words.", result_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
